>>> rtl/ssvs_pkg.sv
// Package with the shared constants, codes and types of the sorted sparse vector set.
`timescale 1ns / 1ps

package ssvs_pkg;

   localparam int CAPACITY        = 64;
   localparam int VALUE_WIDTH     = 32;
   localparam int COLUMN_WIDTH    = 16;
   localparam int LENGTH_WIDTH    = 17;
   localparam int COUNT_WIDTH     = $clog2(CAPACITY + 1);
   localparam int STATUS_WIDTH    = 2;

   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = LENGTH_WIDTH'(65536);

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_RANGE = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   // One classified request as it travels from the front end to the cell row.
   typedef struct packed {
      logic [COLUMN_WIDTH-1:0]       column;
      logic signed [VALUE_WIDTH-1:0] entry_value;
      logic                          out_of_range;
   } item_type;

endpackage

>>> rtl/ssvs_req_if.sv
// Request channel interface: column and value with a valid/ready handshake.
`timescale 1ns / 1ps

interface ssvs_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [ssvs_pkg::COLUMN_WIDTH-1:0]      column;
   logic signed [ssvs_pkg::VALUE_WIDTH-1:0] entry_value;

   modport source (output valid, output column, output entry_value, input ready);
   modport sink   (input valid, input column, input entry_value, output ready);
endinterface

>>> rtl/ssvs_rsp_if.sv
// Response channel interface: status and stored entry count with a valid/ready handshake.
`timescale 1ns / 1ps

interface ssvs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ssvs_pkg::STATUS_WIDTH-1:0] status;
   logic [ssvs_pkg::COUNT_WIDTH-1:0]  nonzero_count;

   modport source (output valid, output status, output nonzero_count, input ready);
   modport sink   (input valid, input status, input nonzero_count, output ready);
endinterface

>>> rtl/ssvs_front.sv
// Front end: holds the vector length register and classifies each incoming request.
`timescale 1ns / 1ps

module ssvs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [ssvs_pkg::LENGTH_WIDTH-1:0] csr_write_data,
   ssvs_req_if.sink                          req_bus,
   input  logic                              queue_full,
   output logic                              push,
   output ssvs_pkg::item_type                push_item
);

   logic [ssvs_pkg::LENGTH_WIDTH-1:0] length_ff;
   logic [ssvs_pkg::LENGTH_WIDTH-1:0] length_in;

   always_comb begin
      length_in = csr_write_enable ? csr_write_data : length_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= ssvs_pkg::LENGTH_RESET;
      end else begin
         length_ff <= length_in;
      end
   end

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   always_comb begin
      push_item.column       = req_bus.column;
      push_item.entry_value  = req_bus.entry_value;
      // The range check happens here; the cell row applies no update for a request flagged out of range.
      push_item.out_of_range = {1'b0, req_bus.column} >= length_ff;
   end

endmodule

>>> rtl/ssvs_queue.sv
// Small first-in first-out queue of classified requests between front end and cell row.
`timescale 1ns / 1ps

module ssvs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssvs_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output ssvs_pkg::item_type head_item
);

   ssvs_pkg::item_type entry_ff [ssvs_pkg::QUEUE_DEPTH];

   logic [ssvs_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ssvs_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ssvs_pkg::QUEUE_CNT_WIDTH-1:0] fill_ff, fill_in;

   assign full      = fill_ff == ssvs_pkg::QUEUE_CNT_WIDTH'(ssvs_pkg::QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/ssvs_back.sv
// Back end: a row of compare-and-shift cells holding the sorted pairs, plus the response register.
`timescale 1ns / 1ps

module ssvs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  ssvs_pkg::item_type head_item,
   output logic               pop,
   ssvs_rsp_if.source         rsp_bus
);

   localparam int Cap = ssvs_pkg::CAPACITY;

   logic [ssvs_pkg::COLUMN_WIDTH-1:0]       col_ff [Cap];
   logic [ssvs_pkg::COLUMN_WIDTH-1:0]       col_in [Cap];
   logic signed [ssvs_pkg::VALUE_WIDTH-1:0] val_ff [Cap];
   logic signed [ssvs_pkg::VALUE_WIDTH-1:0] val_in [Cap];

   logic [ssvs_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic [Cap-1:0] below;   // cell holds a pair whose column is below the request
   logic [Cap-1:0] match;   // cell holds the requested column

   logic found, is_zero, is_full;
   logic do_write, do_delete, do_insert;

   logic                             rsp_valid_ff, rsp_valid_in;
   ssvs_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [ssvs_pkg::COUNT_WIDTH-1:0] rsp_count_ff;

   assign pop = head_valid && (!rsp_valid_ff || rsp_bus.ready);

   assign found   = |match;
   assign is_zero = head_item.entry_value == '0;
   assign is_full = count_ff == ssvs_pkg::COUNT_WIDTH'(Cap);

   assign do_write  = pop && !head_item.out_of_range && found && !is_zero;
   assign do_delete = pop && !head_item.out_of_range && found && is_zero;
   assign do_insert = pop && !head_item.out_of_range && !found && !is_zero && !is_full;

   for (genvar i = 0; i < Cap; i++) begin : g_cell
      localparam logic [ssvs_pkg::COUNT_WIDTH-1:0] CellIndex = ssvs_pkg::COUNT_WIDTH'(i);

      logic occupied;
      logic prev_below;

      assign occupied = CellIndex < count_ff;
      assign below[i] = occupied && (col_ff[i] < head_item.column);
      assign match[i] = occupied && (col_ff[i] == head_item.column);

      if (i == 0) begin : g_first
         assign prev_below = 1'b1;
      end else begin : g_rest
         assign prev_below = below[i-1];
      end

      always_comb begin
         col_in[i] = col_ff[i];
         val_in[i] = val_ff[i];
         if (do_write && match[i]) begin
            val_in[i] = head_item.entry_value;
         end else if (do_insert && !below[i]) begin
            if (prev_below) begin
               col_in[i] = head_item.column;
               val_in[i] = head_item.entry_value;
            end else begin
               col_in[i] = col_ff[(i > 0) ? i - 1 : 0];
               val_in[i] = val_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_delete && !below[i]) begin
            col_in[i] = col_ff[(i < Cap - 1) ? i + 1 : i];
            val_in[i] = val_ff[(i < Cap - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         col_ff[i] <= col_in[i];
         val_ff[i] <= val_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (do_delete) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      priority if (head_item.out_of_range) begin
         rsp_status_in = ssvs_pkg::STATUS_RANGE;
      end else if (!found && !is_zero && is_full) begin
         rsp_status_in = ssvs_pkg::STATUS_FULL;
      end else begin
         rsp_status_in = ssvs_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.nonzero_count = rsp_count_ff;

endmodule

>>> rtl/sorted_sparse_vector_set_top.sv
// Top level of the sorted sparse vector set: front end, request queue and cell row.
`timescale 1ns / 1ps

// The block keeps a sparse vector as up to 64 (column, value) pairs sorted by column.
// Each request on req_bus sets one column to a value: a zero value removes the pair,
// a nonzero value overwrites it or inserts a new pair in sorted position. Every request
// yields exactly one response on rsp_bus with a status (success, column out of range,
// or store full) and the number of stored pairs after the update.
// The csr port writes the vector length; a column at or beyond it is refused. Write it
// only while no request is in flight.
// A request accepted on req_bus is classified and queued; the cell row takes it from
// the queue head once the response register is free and registers its response.
// The cell row compares and shifts all pairs in parallel, so it finishes one request per
// cycle and the block sustains one request per cycle while rsp_bus.ready stays high.
// When the receiver holds rsp_bus.ready low, the response register holds its value and
// the four-entry queue absorbs further requests; req_bus.ready falls when it is full.
// Synchronous reset empties the store, clears the queue and any pending response, and
// sets the vector length to 65536 so that every 16-bit column is in range.

module sorted_sparse_vector_set_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [ssvs_pkg::LENGTH_WIDTH-1:0] csr_write_data,
   ssvs_req_if.sink                          req_bus,
   ssvs_rsp_if.source                        rsp_bus
);

   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_not_empty;
   ssvs_pkg::item_type push_item;
   ssvs_pkg::item_type head_item;

   ssvs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   ssvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   ssvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

>>> rtl/ssvs_checker.sv
// Port-level checks of the sorted sparse vector set, bound to its top level.
`timescale 1ns / 1ps

module ssvs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ssvs_pkg::STATUS_WIDTH-1:0] rsp_status,
   input logic [ssvs_pkg::COUNT_WIDTH-1:0]  rsp_nonzero_count
);

   // A pending response is not withdrawn while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The count in a valid response never exceeds the capacity of the store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nonzero_count <= ssvs_pkg::COUNT_WIDTH'(ssvs_pkg::CAPACITY))
      else $error("entry count above capacity");

   // A full refusal is only reported when the store really is full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ssvs_pkg::STATUS_FULL
      |-> rsp_nonzero_count == ssvs_pkg::COUNT_WIDTH'(ssvs_pkg::CAPACITY))
      else $error("full status with free space");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_sparse_vector_set_top ssvs_checker u_ssvs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_nonzero_count (rsp_bus.nonzero_count)
);
